@@ rtl/core/tsp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the saturating adder for the tour solver.
// No dependencies; used by tsp_solver, tsp_bitmask_dp_solver and tsp_checker.
package tsp_pkg;

    localparam int MAX_CITIES  = 12;
    localparam int CITY_W      = 4;
    localparam int SUBSET_W    = MAX_CITIES;
    localparam int DIST_W      = 16;
    localparam int COST_W      = 32;
    localparam int DIST_ADDR_W = 2 * CITY_W;
    localparam int DIST_DEPTH  = 1 << DIST_ADDR_W;
    localparam int PATH_ADDR_W = CITY_W + SUBSET_W;
    localparam int PATH_DEPTH  = MAX_CITIES * (1 << SUBSET_W);
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;

    localparam logic [COST_W-1:0] COST_INF = '1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SOLVE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [CITY_W-1:0] row;
        logic [CITY_W-1:0] col;
        logic [DIST_W-1:0] distance;
    } load_req_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] cost;
        logic              saturated;
    } solve_result_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {{(COST_W-DIST_W+1){1'b0}}, b};
        if (a == COST_INF || s >= {1'b0, COST_INF})
        begin
            return COST_INF;
        end
        return s[COST_W-1:0];
    endfunction

endpackage

@@ rtl/core/tsp_bitmask_dp_solver.sv @@
`timescale 1ns / 1ps
// Top level of the exact tour cost solver: stream handshake, configuration
// register and output register. Depends on tsp_pkg and tsp_solver.
//
// Usage: the input stream carries either a distance load (tuser = 0) or a
// solve request (tuser = 1). A load writes one directed distance into the
// distance memory; loads can be sent back to back while no solve runs. A load
// naming a city of 12 or above is dropped. A solve produces exactly one output
// transaction holding the cheapest closed tour over cities 0..last_city_index
// from city 0, and the saturated flag in tuser. cfg_wr_en writes
// last_city_index (reset value 1), and values above 11 act as 11.
// A solve with n = last_city_index walks every visited-city mask 0..2^(n+1)-1;
// per mask it selects each of the n+1 cities in turn and, for each city in
// the mask, reads the path cost and distance of each other city in the mask
// one at a time through the one read port of the path cost memory, then
// drains the read pipeline and writes the best cost; a closing pass adds the
// return to city 0. No input is accepted while a solve runs. The path cost
// memory needs no clearing: every entry is written before it is read.
// Reset empties the output register and aborts any solve; the distance memory
// keeps undefined contents until loaded. If the receiver stalls, the result
// waits in the output register and further loads are still accepted, but the
// next solve result waits until the register is free.
module tsp_bitmask_dp_solver
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // from_city [3:0], to_city [7:4], distance [23:8].
    input  logic [tsp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func [0].
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tour_cost [31:0].
    output logic [tsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // saturated [0].
    output logic                            m_axis_tuser,
    input  logic                            cfg_wr_en,
    input  logic [tsp_pkg::CITY_W-1:0]      cfg_wr_data
);

    logic [tsp_pkg::CITY_W-1:0]     last_city_reg;
    logic                           m_valid_reg;
    logic [tsp_pkg::COST_W-1:0]     m_cost_reg;
    logic                           m_sat_reg;

    tsp_pkg::load_req_t             load;
    tsp_pkg::solve_result_t         result;
    logic                           busy;
    logic                           in_acc;
    logic                           start;
    logic                           out_free;
    logic                           result_taken;
    logic [tsp_pkg::CITY_W-1:0]     from_city;
    logic [tsp_pkg::CITY_W-1:0]     to_city;

    assign from_city = s_axis_tdata[tsp_pkg::CITY_W-1:0];
    assign to_city   = s_axis_tdata[2*tsp_pkg::CITY_W-1:tsp_pkg::CITY_W];

    assign s_axis_tready = !busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign start         = in_acc && (s_axis_tuser == tsp_pkg::FUNC_SOLVE);

    assign load.valid    = in_acc && (s_axis_tuser == tsp_pkg::FUNC_LOAD)
                        && (from_city < tsp_pkg::CITY_W'(tsp_pkg::MAX_CITIES))
                        && (to_city < tsp_pkg::CITY_W'(tsp_pkg::MAX_CITIES));
    assign load.row      = from_city;
    assign load.col      = to_city;
    assign load.distance = s_axis_tdata[2*tsp_pkg::CITY_W+tsp_pkg::DIST_W-1:2*tsp_pkg::CITY_W];

    assign out_free     = !m_valid_reg || m_axis_tready;
    assign result_taken = result.valid && out_free;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_cost_reg;
    assign m_axis_tuser  = m_sat_reg;

    tsp_solver u_solver
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .start        (start),
        .n_cfg        (last_city_reg),
        .result_taken (result_taken),
        .busy         (busy),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_city_reg <= tsp_pkg::CITY_W'(1);
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                last_city_reg <= cfg_wr_data;
            end
            if (result_taken)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_taken)
        begin
            m_cost_reg <= result.cost;
            m_sat_reg  <= result.saturated;
        end
    end

endmodule

@@ rtl/core/tsp_solver.sv @@
`timescale 1ns / 1ps
// Subset DP engine: distance memory, path cost memory and the sequencer over them.
// Depends on tsp_pkg.
module tsp_solver
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsp_pkg::load_req_t          load,
    input  logic                        start,
    input  logic [tsp_pkg::CITY_W-1:0]  n_cfg,
    input  logic                        result_taken,
    output logic                        busy,
    output tsp_pkg::solve_result_t      result
);

    typedef enum logic [2:0] {S_IDLE, S_SELECT, S_RUN, S_DRAIN, S_RESULT} state_t;

    state_t                               state_reg;
    logic [tsp_pkg::DIST_W-1:0]           dist_mem [0:tsp_pkg::DIST_DEPTH-1];
    logic [tsp_pkg::COST_W-1:0]           path_mem [0:tsp_pkg::PATH_DEPTH-1];
    logic [tsp_pkg::DIST_W-1:0]           dist_rdata_reg;
    logic [tsp_pkg::COST_W-1:0]           path_rdata_reg;
    logic [tsp_pkg::CITY_W-1:0]           n_reg;
    logic [tsp_pkg::SUBSET_W-1:0]         full_reg;
    logic [tsp_pkg::SUBSET_W-1:0]         sta_reg;
    logic [tsp_pkg::CITY_W-1:0]           i_reg;
    logic [tsp_pkg::CITY_W-1:0]           k_reg;
    logic                                 final_reg;
    logic                                 p1_valid_reg;
    logic                                 p2_valid_reg;
    logic [tsp_pkg::COST_W-1:0]           sum_reg;
    logic [tsp_pkg::COST_W-1:0]           acc_reg;
    logic [tsp_pkg::COST_W-1:0]           cost_reg;

    logic [tsp_pkg::CITY_W-1:0]           n_clamp;
    logic [tsp_pkg::SUBSET_W:0]           full_wide;
    logic [tsp_pkg::SUBSET_W-1:0]         prev_mask;
    logic [tsp_pkg::SUBSET_W-1:0]         rd_mask;
    logic [tsp_pkg::PATH_ADDR_W-1:0]      path_rd_addr;
    logic [tsp_pkg::PATH_ADDR_W-1:0]      path_wr_addr;
    logic [tsp_pkg::DIST_ADDR_W-1:0]      dist_rd_addr;
    logic [tsp_pkg::CITY_W-1:0]           dist_col;
    logic                                 issue;
    logic                                 group_done;
    logic                                 path_we;
    logic                                 last_i;
    logic                                 last_sta;
    logic [tsp_pkg::COST_W-1:0]           sum_next;

    assign n_clamp = (n_cfg > tsp_pkg::CITY_W'(tsp_pkg::MAX_CITIES - 1))
                   ? tsp_pkg::CITY_W'(tsp_pkg::MAX_CITIES - 1) : n_cfg;
    assign full_wide = ((tsp_pkg::SUBSET_W+1)'(1) << ({1'b0, n_clamp} + 5'd1))
                     - (tsp_pkg::SUBSET_W+1)'(1);

    assign prev_mask    = sta_reg ^ (tsp_pkg::SUBSET_W'(1) << i_reg);
    assign rd_mask      = final_reg ? full_reg : prev_mask;
    assign dist_col     = final_reg ? '0 : i_reg;
    assign path_rd_addr = {k_reg, rd_mask};
    assign path_wr_addr = {i_reg, sta_reg};
    assign dist_rd_addr = {k_reg, dist_col};

    assign issue = (state_reg == S_RUN)
                && (final_reg ? (k_reg != '0) : (sta_reg[k_reg] && (k_reg != i_reg)));
    assign group_done = (state_reg == S_DRAIN) && !p1_valid_reg && !p2_valid_reg;
    assign path_we    = group_done && !final_reg;
    assign last_i     = (i_reg == n_reg);
    assign last_sta   = (sta_reg == full_reg);
    assign sum_next   = tsp_pkg::sat_add(path_rdata_reg, dist_rdata_reg);

    assign busy             = (state_reg != S_IDLE);
    assign result.valid     = (state_reg == S_RESULT);
    assign result.cost      = cost_reg;
    assign result.saturated = (cost_reg == tsp_pkg::COST_INF);

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            dist_mem[{load.row, load.col}] <= load.distance;
        end
        if (issue)
        begin
            dist_rdata_reg <= dist_mem[dist_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[path_wr_addr] <= acc_reg;
        end
        if (issue)
        begin
            path_rdata_reg <= path_mem[path_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            full_reg     <= '0;
            sta_reg      <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
            final_reg    <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            cost_reg     <= '0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (n_clamp == '0)
                        begin
                            cost_reg  <= tsp_pkg::COST_INF;
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            n_reg     <= n_clamp;
                            full_reg  <= full_wide[tsp_pkg::SUBSET_W-1:0];
                            sta_reg   <= '0;
                            i_reg     <= '0;
                            final_reg <= 1'b0;
                            state_reg <= S_SELECT;
                        end
                    end
                end
                S_SELECT:
                begin
                    if (sta_reg[i_reg])
                    begin
                        acc_reg   <= (sta_reg == tsp_pkg::SUBSET_W'(1) && i_reg == '0)
                                   ? '0 : tsp_pkg::COST_INF;
                        k_reg     <= '0;
                        state_reg <= S_RUN;
                    end
                    else if (!last_i)
                    begin
                        i_reg <= i_reg + tsp_pkg::CITY_W'(1);
                    end
                    else if (!last_sta)
                    begin
                        i_reg   <= '0;
                        sta_reg <= sta_reg + tsp_pkg::SUBSET_W'(1);
                    end
                    else
                    begin
                        final_reg <= 1'b1;
                        k_reg     <= '0;
                        acc_reg   <= tsp_pkg::COST_INF;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    k_reg <= k_reg + tsp_pkg::CITY_W'(1);
                    if (k_reg == n_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (group_done)
                    begin
                        if (final_reg)
                        begin
                            cost_reg  <= acc_reg;
                            state_reg <= S_RESULT;
                        end
                        else if (!last_i)
                        begin
                            i_reg     <= i_reg + tsp_pkg::CITY_W'(1);
                            state_reg <= S_SELECT;
                        end
                        else if (!last_sta)
                        begin
                            i_reg     <= '0;
                            sta_reg   <= sta_reg + tsp_pkg::SUBSET_W'(1);
                            state_reg <= S_SELECT;
                        end
                        else
                        begin
                            final_reg <= 1'b1;
                            k_reg     <= '0;
                            acc_reg   <= tsp_pkg::COST_INF;
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RESULT:
                begin
                    if (result_taken)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (p2_valid_reg && (sum_reg < acc_reg))
            begin
                acc_reg <= sum_reg;
            end
        end
    end

endmodule

@@ rtl/core/tsp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the tour solver and the bind that attaches them.
// Depends on tsp_pkg and tsp_bitmask_dp_solver.
module tsp_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                               && $stable(m_axis_tuser)))
        else $error("Stalled output transaction changed.");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata == tsp_pkg::COST_INF)))
        else $error("Saturated flag disagrees with tour cost.");

    a_solve_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == tsp_pkg::FUNC_SOLVE))
        |=> !s_axis_tready)
        else $error("Input accepted while a solve runs.");

endmodule

bind tsp_bitmask_dp_solver tsp_checker u_tsp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
